/* rtl/core/ght_pkg.sv */
package ght_pkg;

  localparam int DEF_NUM_SLOTS = 1024;
  localparam int DEF_GEN_SHIFT = 12;

  localparam int ACT_W  = 2;
  localparam int ID_W   = 31;
  localparam int SLOT_W = 10;
  localparam int STAT_W = 2;

  // padded stream widths
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_RUN    = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_SLOT = 2'd1,
    STAT_BAD     = 2'd2
  } status_t;

  typedef struct packed {
    action_t           action;
    logic [ID_W-1:0]   handle_id;
    logic [ID_W-1:0]   owner_id;
    logic [SLOT_W-1:0] slot;
    logic              check_owner;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic              slot_valid;
    logic [SLOT_W-1:0] slot_index;
    logic [ID_W-1:0]   slot_id;
  } res_t;

  // state updates decided by the evaluation stage
  typedef struct packed {
    logic we;
    logic pop;
    logic push;
    logic run;
  } upd_t;

endpackage

/* rtl/core/generational_handle_table.sv */
// channel | direction | tdata fields (lsb first)                           | tuser
// in_     | slave     | handle_id 31, owner_id 31, slot 10, check_owner 1  | action 2
// out_    | master    | status 2, slot_valid 1, slot_index 10, slot_id 31  | -
//
// a transaction runs from the accept cycle, which issues the slot table read, to
// the evaluation state, which evaluates the entry, writes it back and loads the result register
// the registered read of the slot table lies ahead of the write-back
// after reset a clearing pass over all NUM_SLOTS entries initializes the table; no input
// transaction is taken during it
// a result waiting in the output register does not block the next accept; the
// evaluation cycle holds only while the output register is still full
module generational_handle_table
  import ght_pkg::*;
#(
  parameter int NUM_SLOTS = DEF_NUM_SLOTS,
  parameter int GEN_SHIFT = DEF_GEN_SHIFT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // handle_id, owner_id, slot, check_owner
  input  logic [ACT_W-1:0]      in_tuser,   // action
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // status, slot_valid, slot_index, slot_id
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int ENT_W = 1 + 2 * ID_W + IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  // one-hot control states
  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  clr_idx_r, clr_idx_nxt;
  req_t              req_r, req_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              rng_r, rng_nxt;
  logic [IDX_W-1:0]  free_head_r, free_head_nxt;
  logic [CNT_W-1:0]  free_cnt_r, free_cnt_nxt;
  logic [IDX_W-1:0]  cur_slot_r, cur_slot_nxt;
  logic              cur_valid_r, cur_valid_nxt;
  logic [ID_W-1:0]   cur_id_r, cur_id_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r, out_res_nxt;

  req_t              in_req;
  logic [31:0]       in_slot32;
  logic [IDX_W-1:0]  in_idx;
  logic              in_fire;
  logic              exec_fire;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [ENT_W-1:0]  ram_wdata;
  logic [ENT_W-1:0]  ram_rdata;

  logic              ent_live;
  logic [ID_W-1:0]   ent_id;
  logic [ID_W-1:0]   ent_owner;
  logic [IDX_W-1:0]  ent_next;

  res_t              ev_res;
  upd_t              ev_upd;
  logic              wr_live;
  logic [ID_W-1:0]   wr_id;
  logic [ID_W-1:0]   wr_owner;
  logic [IDX_W-1:0]  wr_next;
  logic [IDX_W-1:0]  clr_next;

  // unpack the input transaction
  assign in_req.action      = action_t'(in_tuser);
  assign in_req.handle_id   = in_tdata[30:0];
  assign in_req.owner_id    = in_tdata[61:31];
  assign in_req.slot        = in_tdata[71:62];
  assign in_req.check_owner = in_tdata[72];

  assign in_slot32 = 32'(in_req.slot);

  // table address for the entry the request touches
  always_comb begin
    unique case (in_req.action)
      ACT_ALLOC:  in_idx = free_head_r;
      ACT_FREE:   in_idx = in_slot32[IDX_W-1:0];
      ACT_LOOKUP: in_idx = in_req.handle_id[IDX_W-1:0] & LAST_IDX;
      ACT_RUN:    in_idx = in_slot32[IDX_W-1:0];
      default:    in_idx = free_head_r;
    endcase
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign exec_fire = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  // slot table: {live, id, owner, next link} per entry
  assign {ent_live, ent_id, ent_owner, ent_next} = ram_rdata;

  assign clr_next = (clr_idx_r == LAST_IDX) ? '0 : clr_idx_r + 1'b1;

  always_comb begin
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_r;
      ram_wdata = {1'b0, {ID_W{1'b0}}, {ID_W{1'b0}}, clr_next};
    end else begin
      ram_we    = exec_fire && ev_upd.we;
      ram_waddr = idx_r;
      ram_wdata = {wr_live, wr_id, wr_owner, wr_next};
    end
  end

  ght_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  ght_eval #(
    .NUM_SLOTS (NUM_SLOTS),
    .GEN_SHIFT (GEN_SHIFT)
  ) u_eval (
    .req           (req_r),
    .idx           (idx_r),
    .slot_in_range (rng_r),
    .ent_live      (ent_live),
    .ent_id        (ent_id),
    .ent_owner     (ent_owner),
    .ent_next      (ent_next),
    .free_head     (free_head_r),
    .free_empty    (free_cnt_r == '0),
    .cur_slot      (cur_slot_r),
    .cur_valid     (cur_valid_r),
    .cur_id        (cur_id_r),
    .res           (ev_res),
    .upd           (ev_upd),
    .wr_live       (wr_live),
    .wr_id         (wr_id),
    .wr_owner      (wr_owner),
    .wr_next       (wr_next)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    rng_nxt       = rng_r;
    free_head_nxt = free_head_r;
    free_cnt_nxt  = free_cnt_r;
    cur_slot_nxt  = cur_slot_r;
    cur_valid_nxt = cur_valid_r;
    cur_id_nxt    = cur_id_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_res_nxt   = out_res_r;

    unique case (state_r)
      S_CLEAR: begin
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          req_nxt   = in_req;
          idx_nxt   = in_idx;
          rng_nxt   = in_slot32 < 32'(NUM_SLOTS);
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = ev_res;
          state_nxt     = S_IDLE;
          if (ev_upd.pop) begin
            free_head_nxt = ent_next;
            free_cnt_nxt  = free_cnt_r - 1'b1;
          end
          if (ev_upd.push) begin
            free_head_nxt = idx_r;
            free_cnt_nxt  = free_cnt_r + 1'b1;
          end
          // keep a copy of the current slot's id for owner checks and id 0
          if (ev_upd.we && (idx_r == cur_slot_r)) begin
            cur_id_nxt = wr_id;
          end
          if (ev_upd.run) begin
            cur_slot_nxt  = idx_r;
            cur_valid_nxt = 1'b1;
            cur_id_nxt    = ent_id;
          end
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      free_head_r <= '0;
      free_cnt_r  <= CNT_W'(NUM_SLOTS);
      cur_slot_r  <= '0;
      cur_valid_r <= 1'b0;
      cur_id_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      free_head_r <= free_head_nxt;
      free_cnt_r  <= free_cnt_nxt;
      cur_slot_r  <= cur_slot_nxt;
      cur_valid_r <= cur_valid_nxt;
      cur_id_r    <= cur_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    idx_r     <= idx_nxt;
    rng_r     <= rng_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r.slot_id, out_res_r.slot_index,
                       out_res_r.slot_valid, out_res_r.status};

endmodule

/* rtl/core/ght_ram.sv */
module ght_ram
  import ght_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/ght_eval.sv */
module ght_eval
  import ght_pkg::*;
#(
  parameter int NUM_SLOTS = DEF_NUM_SLOTS,
  parameter int GEN_SHIFT = DEF_GEN_SHIFT,
  localparam int IDX_W = $clog2(NUM_SLOTS)
) (
  input  req_t             req,
  input  logic [IDX_W-1:0] idx,
  input  logic             slot_in_range,
  input  logic             ent_live,
  input  logic [ID_W-1:0]  ent_id,
  input  logic [ID_W-1:0]  ent_owner,
  input  logic [IDX_W-1:0] ent_next,
  input  logic [IDX_W-1:0] free_head,
  input  logic             free_empty,
  input  logic [IDX_W-1:0] cur_slot,
  input  logic             cur_valid,
  input  logic [ID_W-1:0]  cur_id,
  output res_t             res,
  output upd_t             upd,
  output logic             wr_live,
  output logic [ID_W-1:0]  wr_id,
  output logic [ID_W-1:0]  wr_owner,
  output logic [IDX_W-1:0] wr_next
);

  localparam logic [31:0] GEN_STEP = 32'd1 << GEN_SHIFT;
  localparam logic [31:0] IDX_CLR  = ~(32'(NUM_SLOTS) - 32'd1);

  logic [31:0]       gen_sum;
  logic [31:0]       gen_raw;
  logic [31:0]       gen;
  logic [ID_W-1:0]   new_id;
  logic [31:0]       idx32;
  logic [31:0]       cur32;
  logic [SLOT_W-1:0] idx_out;
  logic [SLOT_W-1:0] cur_out;
  logic              owner_ok;

  // next generation: bump, clear the index bits, wrap if non-positive
  always_comb begin
    gen_sum = {1'b0, ent_id} + GEN_STEP;
    gen_raw = gen_sum & IDX_CLR;
    gen     = ((gen_raw == 32'd0) || gen_raw[31]) ? GEN_STEP : gen_raw;
    new_id  = gen[ID_W-1:0] | ID_W'(idx);
  end

  assign idx32   = 32'(idx);
  assign cur32   = 32'(cur_slot);
  assign idx_out = idx32[SLOT_W-1:0];
  assign cur_out = cur32[SLOT_W-1:0];

  assign owner_ok = !req.check_owner ||
                    (cur_valid && ((idx == cur_slot) || (ent_owner == cur_id)));

  always_comb begin
    res      = '{status: STAT_BAD, slot_valid: 1'b0, slot_index: '0, slot_id: '0};
    upd      = '0;
    wr_live  = ent_live;
    wr_id    = ent_id;
    wr_owner = ent_owner;
    wr_next  = ent_next;
    unique case (req.action)
      ACT_ALLOC: begin
        if (free_empty) begin
          res.status = STAT_NO_SLOT;
        end else begin
          upd.we   = 1'b1;
          upd.pop  = 1'b1;
          wr_live  = 1'b1;
          wr_id    = new_id;
          wr_owner = req.owner_id;
          res      = '{status: STAT_OK, slot_valid: 1'b1, slot_index: idx_out,
                       slot_id: new_id};
        end
      end
      ACT_FREE: begin
        if (slot_in_range && ent_live) begin
          upd.we   = 1'b1;
          upd.push = 1'b1;
          wr_live  = 1'b0;
          wr_next  = free_head;
          res      = '{status: STAT_OK, slot_valid: 1'b1, slot_index: idx_out,
                       slot_id: ent_id};
        end
      end
      ACT_LOOKUP: begin
        if (req.handle_id == '0) begin
          res.status = STAT_OK;
          if (cur_valid) begin
            res.slot_valid = 1'b1;
            res.slot_index = cur_out;
            res.slot_id    = cur_id;
          end
        end else if (ent_live && (ent_id == req.handle_id) && owner_ok) begin
          res = '{status: STAT_OK, slot_valid: 1'b1, slot_index: idx_out,
                  slot_id: ent_id};
        end
      end
      ACT_RUN: begin
        if (slot_in_range && ent_live) begin
          upd.run = 1'b1;
          res     = '{status: STAT_OK, slot_valid: 1'b1, slot_index: idx_out,
                      slot_id: ent_id};
        end
      end
      default: begin
        res.status = STAT_BAD;
      end
    endcase
  end

endmodule

/* rtl/core/ght_checker.sv */
module ght_checker
  import ght_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("undefined status code");

  // a failing transaction returns no slot
  a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != STAT_OK) |-> out_tdata[43:2] == '0)
    else $error("failed transaction carries a slot");

  // every returned slot has a nonzero generational id
  a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[43:13] != '0)
    else $error("returned slot with zero id");

  // one transaction at a time: no accept right after an accept
  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accept in consecutive cycles");

endmodule

bind generational_handle_table ght_checker u_ght_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
